>>> rtl/core/kvc_pkg.sv
`timescale 1ns / 1ps

package kvc_pkg;

    // Field widths
    localparam int ModeW   = 3;
    localparam int CharW   = 8;
    localparam int StatusW = 3;
    localparam int LetterW = 5;

    // Alphabet and keyword store sizes
    localparam int AlphaN     = 26;
    localparam int AlphaLenW  = $clog2(AlphaN + 1);
    localparam int MaxKeyword = 256;
    localparam int KwAddrW    = (MaxKeyword > 1) ? $clog2(MaxKeyword) : 1;
    localparam int KwLenW     = $clog2(MaxKeyword + 1);

    // ASCII codes used by the text filter
    localparam logic [CharW-1:0] CharUpA  = 8'h41;
    localparam logic [CharW-1:0] CharUpZ  = 8'h5A;
    localparam logic [CharW-1:0] CharLowA = 8'h61;
    localparam logic [CharW-1:0] CharLowZ = 8'h7A;
    localparam logic [CharW-1:0] CharDot  = 8'h2E;
    localparam logic [LetterW-1:0] LetterX = 5'd23;

    typedef logic [LetterW-1:0] t_letter;

    // Alphabet key after reset: K R Y P T O S
    localparam int AlphaSeedLen = 7;
    localparam t_letter AlphaSeed [AlphaSeedLen] = '{
        5'd10, 5'd17, 5'd24, 5'd15, 5'd19, 5'd14, 5'd18
    };

    // Keyword after reset: H I D D E N
    localparam int KwSeedMax = 6;
    localparam int KwSeedLen = (MaxKeyword < KwSeedMax) ? MaxKeyword : KwSeedMax;
    localparam t_letter KwSeed [KwSeedMax] = '{
        5'd7, 5'd8, 5'd3, 5'd3, 5'd4, 5'd13
    };

    typedef enum logic [ModeW-1:0] {
        ModeAlphaKey = 3'd0,
        ModeKeyword  = 3'd1,
        ModeEncrypt  = 3'd2,
        ModeDecrypt  = 3'd3,
        ModeRestart  = 3'd4,
        ModeClear    = 3'd5
    } t_mode;

    typedef enum logic [StatusW-1:0] {
        StOk      = 3'd0,
        StBadChar = 3'd1,
        StRepeat  = 3'd2,
        StFull    = 3'd3,
        StEmptyKw = 3'd4
    } t_status;

    typedef struct packed {
        logic    add;
        logic    clear;
        t_letter letter;
    } t_alpha_cmd;

    typedef struct packed {
        logic    full;
        logic    used;
        t_letter letter;
    } t_alpha_stat;

    typedef struct packed {
        logic    append;
        logic    advance;
        logic    restart;
        logic    clear;
        t_letter letter;
    } t_kw_cmd;

    typedef struct packed {
        logic    empty;
        logic    full;
        t_letter letter;
    } t_kw_stat;

    // Keyed-alphabet index of letter j for the reset alphabet key.
    // Key letters sit at their key index; the others follow in A..Z order,
    // which puts letter j at j plus the number of key letters above it.
    function automatic t_letter alpha_reset_where(input int j);
        int pos;
        int above;
        pos   = -1;
        above = 0;
        for (int i = 0; i < AlphaSeedLen; i++) begin
            if (int'(AlphaSeed[i]) == j) begin
                pos = i;
            end
            if (int'(AlphaSeed[i]) > j) begin
                above = above + 1;
            end
        end
        if (pos < 0) begin
            pos = j + above;
        end
        return LetterW'(pos);
    endfunction

    function automatic logic [AlphaN-1:0] alpha_reset_map();
        logic [AlphaN-1:0] m;
        m = '0;
        for (int i = 0; i < AlphaSeedLen; i++) begin
            m[AlphaSeed[i]] = 1'b1;
        end
        return m;
    endfunction

endpackage

>>> rtl/core/kvc_if.sv
`timescale 1ns / 1ps

// Request channel: one command byte
interface kvc_in_if;
    logic                         valid;
    logic                         ready;
    logic [kvc_pkg::ModeW-1:0]    mode;
    logic [kvc_pkg::CharW-1:0]    in_char;

    modport source (output valid, output mode, output in_char, input ready);
    modport sink   (input valid, input mode, input in_char, output ready);
endinterface

// Result channel: one letter and a status code
interface kvc_out_if;
    logic                         valid;
    logic                         ready;
    logic [kvc_pkg::CharW-1:0]    out_char;
    logic [kvc_pkg::StatusW-1:0]  status;

    modport source (output valid, output out_char, output status, input ready);
    modport sink   (input valid, input out_char, input status, output ready);
endinterface

>>> rtl/core/kvc_ram.sv
`timescale 1ns / 1ps

module kvc_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_waddr,
    input  logic [Width-1:0]                        i_wdata,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_raddr,
    output logic [Width-1:0]                        o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/kvc_alpha.sv
`timescale 1ns / 1ps

module kvc_alpha (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kvc_pkg::t_alpha_cmd  i_cmd,
    input  kvc_pkg::t_letter     i_c_letter,
    input  kvc_pkg::t_letter     i_k_letter,
    input  logic                 i_decrypt,
    output kvc_pkg::t_alpha_stat o_stat
);
    import kvc_pkg::*;

    // Keyed-alphabet index of every letter, kept as two identical copies:
    // one looked up by the text letter, one by the keyword letter.
    t_letter                r_where_c [AlphaN];
    t_letter                r_where_k [AlphaN];
    t_letter                n_where   [AlphaN];
    logic [AlphaN-1:0]      r_used;
    logic [AlphaN-1:0]      n_used;
    logic [AlphaLenW-1:0]   r_alen;
    logic [AlphaLenW-1:0]   n_alen;

    t_letter                x_pos;
    t_letter                y_pos;
    logic [LetterW:0]       sum;
    t_letter                idx;
    t_letter                res;

    // Key update: a new key letter takes the next key slot; unused letters
    // below it move up one place, the ones above stay.
    always_comb begin
        n_used = r_used;
        n_alen = r_alen;
        for (int j = 0; j < AlphaN; j++) begin
            n_where[j] = r_where_c[j];
        end
        if (i_cmd.clear) begin
            n_used = '0;
            n_alen = '0;
            for (int j = 0; j < AlphaN; j++) begin
                n_where[j] = LetterW'(j);
            end
        end else if (i_cmd.add) begin
            for (int j = 0; j < AlphaN; j++) begin
                if (LetterW'(j) == i_cmd.letter) begin
                    n_where[j] = LetterW'(r_alen);
                end else if (!r_used[j] && (LetterW'(j) < i_cmd.letter)) begin
                    n_where[j] = r_where_c[j] + 1'b1;
                end
            end
            n_used[i_cmd.letter] = 1'b1;
            n_alen = r_alen + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= alpha_reset_map();
            r_alen <= AlphaLenW'(AlphaSeedLen);
            for (int j = 0; j < AlphaN; j++) begin
                r_where_c[j] <= alpha_reset_where(j);
                r_where_k[j] <= alpha_reset_where(j);
            end
        end else begin
            r_used <= n_used;
            r_alen <= n_alen;
            for (int j = 0; j < AlphaN; j++) begin
                r_where_c[j] <= n_where[j];
                r_where_k[j] <= n_where[j];
            end
        end
    end

    // Shift in the keyed alphabet, mod 26
    always_comb begin
        x_pos = r_where_c[i_c_letter];
        y_pos = r_where_k[i_k_letter];
        if (i_decrypt) begin
            sum = {1'b0, x_pos} + (LetterW+1)'(AlphaN) - {1'b0, y_pos};
        end else begin
            sum = {1'b0, x_pos} + {1'b0, y_pos};
        end
        if (sum >= (LetterW+1)'(AlphaN)) begin
            idx = LetterW'(sum - (LetterW+1)'(AlphaN));
        end else begin
            idx = LetterW'(sum);
        end
    end

    // Inverse lookup: the letter whose keyed index is idx
    always_comb begin
        res = '0;
        for (int j = 0; j < AlphaN; j++) begin
            if (r_where_c[j] == idx) begin
                res = LetterW'(j);
            end
        end
    end

    assign o_stat.full   = (r_alen >= AlphaLenW'(AlphaN));
    assign o_stat.used   = r_used[i_c_letter];
    assign o_stat.letter = res;
endmodule

>>> rtl/core/kvc_keyword.sv
`timescale 1ns / 1ps

module kvc_keyword (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kvc_pkg::t_kw_cmd  i_cmd,
    output kvc_pkg::t_kw_stat o_stat
);
    import kvc_pkg::*;

    logic [KwLenW-1:0]  r_kwlen;
    logic [KwLenW-1:0]  n_kwlen;
    logic [KwAddrW-1:0] r_pos;
    logic [KwAddrW-1:0] n_pos;
    logic [KwLenW-1:0]  pos_inc;
    logic               r_seed;
    logic               n_seed;
    logic               r_fix_valid;
    logic               n_fix_valid;
    t_letter            r_fix_data;
    t_letter            n_fix_data;
    logic               seed_hit;
    t_letter            seed_letter;
    logic [KwAddrW-1:0] waddr;
    t_letter            ram_rdata;

    assign waddr   = r_kwlen[KwAddrW-1:0];
    assign pos_inc = KwLenW'(r_pos) + 1'b1;

    // Length, running position and the reset-keyword flag
    always_comb begin
        n_kwlen = r_kwlen;
        n_pos   = r_pos;
        n_seed  = r_seed;
        if (i_cmd.clear) begin
            n_kwlen = '0;
            n_pos   = '0;
            n_seed  = 1'b0;
        end else begin
            if (i_cmd.append) begin
                n_kwlen = r_kwlen + 1'b1;
            end
            if (i_cmd.restart) begin
                n_pos = '0;
            end else if (i_cmd.advance) begin
                n_pos = (pos_inc >= r_kwlen) ? '0 : KwAddrW'(pos_inc);
            end
        end
    end

    // Reset keyword letters are served from constants until the first clear
    always_comb begin
        seed_hit    = 1'b0;
        seed_letter = '0;
        for (int i = 0; i < KwSeedLen; i++) begin
            if (n_pos == KwAddrW'(i)) begin
                seed_hit    = 1'b1;
                seed_letter = KwSeed[i];
            end
        end
    end

    // Override for the RAM read: reset letters, or a write to the slot
    // being read in the same cycle
    always_comb begin
        n_fix_valid = 1'b0;
        n_fix_data  = i_cmd.letter;
        if (n_seed && seed_hit) begin
            n_fix_valid = 1'b1;
            n_fix_data  = seed_letter;
        end else if (i_cmd.append && (waddr == n_pos)) begin
            n_fix_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kwlen     <= KwLenW'(KwSeedLen);
            r_pos       <= '0;
            r_seed      <= 1'b1;
            r_fix_valid <= 1'b1;
            r_fix_data  <= KwSeed[0];
        end else begin
            r_kwlen     <= n_kwlen;
            r_pos       <= n_pos;
            r_seed      <= n_seed;
            r_fix_valid <= n_fix_valid;
            r_fix_data  <= n_fix_data;
        end
    end

    // Keyword letters; read address is n_pos, the next value of r_pos
    kvc_ram #(
        .Width (LetterW),
        .Depth (MaxKeyword)
    ) u_kw_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (waddr),
        .i_wdata (i_cmd.letter),
        .i_raddr (n_pos),
        .o_rdata (ram_rdata)
    );

    assign o_stat.empty  = (r_kwlen == '0);
    assign o_stat.full   = (r_kwlen >= KwLenW'(MaxKeyword));
    assign o_stat.letter = r_fix_valid ? r_fix_data : ram_rdata;
endmodule

>>> rtl/core/keyed_vigenere_cipher.sv
`timescale 1ns / 1ps

// Channel   Dir  Modport            Payload
// i_req     in   kvc_in_if.sink     mode[2:0], in_char[7:0]
// o_rsp     out  kvc_out_if.source  out_char[7:0], status[2:0]
//
// One request per cycle while the result is not stalled. An accepted
// request loads the input register; filter, key lookup and mod-26 shift
// feed the result register. The keyword RAM is addressed with the next
// position. Reset (synchronous, active low) loads the KRYPTOS alphabet
// key and the HIDDEN keyword. A stalled result holds the work stage;
// requests that give no result still wait for it to drain.
module keyed_vigenere_cipher (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kvc_in_if.sink   i_req,
    kvc_out_if.source o_rsp
);
    import kvc_pkg::*;

    // Input register
    logic               r_in_valid;
    logic [ModeW-1:0]   r_in_mode;
    logic [CharW-1:0]   r_in_char;

    // Result register
    logic               r_out_valid;
    logic [CharW-1:0]   r_out_char;
    logic [StatusW-1:0] r_out_status;

    logic               fire;
    logic               is_upper;
    logic               is_lower;
    logic               is_letter;
    logic               is_dot;
    t_letter            raw_letter;
    logic               text_ok;
    t_letter            text_letter;
    t_letter            q_letter;
    logic               has_res;
    t_status            st;
    logic [CharW-1:0]   res_char;
    logic               decrypt;

    t_alpha_cmd         acmd;
    t_alpha_stat        astat;
    t_kw_cmd            kcmd;
    t_kw_stat           kstat;

    // Work stage moves when the result register is free or being drained
    assign fire        = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_mode <= i_req.mode;
            r_in_char <= i_req.in_char;
        end
    end

    // Character filter: raise lower case; '.' stands for X in text
    always_comb begin
        is_upper   = (r_in_char >= CharUpA) && (r_in_char <= CharUpZ);
        is_lower   = (r_in_char >= CharLowA) && (r_in_char <= CharLowZ);
        is_letter  = is_upper || is_lower;
        is_dot     = (r_in_char == CharDot);
        raw_letter = is_lower ? LetterW'(r_in_char - CharLowA)
                              : LetterW'(r_in_char - CharUpA);
        text_ok     = is_letter || is_dot;
        text_letter = is_dot ? LetterX : raw_letter;
        if (is_letter || is_dot) begin
            q_letter = text_letter;
        end else begin
            q_letter = '0;
        end
    end

    // Mode decode and error checks
    always_comb begin
        has_res      = 1'b0;
        st           = StOk;
        res_char     = '0;
        decrypt      = 1'b0;
        acmd         = '0;
        acmd.letter  = q_letter;
        kcmd         = '0;
        kcmd.letter  = q_letter;
        unique case (t_mode'(r_in_mode))
            ModeAlphaKey: begin
                has_res = 1'b1;
                if (!is_letter) begin
                    st = StBadChar;
                end else if (astat.full) begin
                    st = StFull;
                end else if (astat.used) begin
                    st = StRepeat;
                end else begin
                    acmd.add = fire;
                end
            end
            ModeKeyword: begin
                has_res = 1'b1;
                if (!is_letter) begin
                    st = StBadChar;
                end else if (kstat.full) begin
                    st = StFull;
                end else begin
                    kcmd.append = fire;
                end
            end
            ModeEncrypt, ModeDecrypt: begin
                decrypt = (t_mode'(r_in_mode) == ModeDecrypt);
                if (text_ok) begin
                    has_res = 1'b1;
                    if (kstat.empty) begin
                        st = StEmptyKw;
                    end else begin
                        res_char     = CharW'(astat.letter) + CharUpA;
                        kcmd.advance = fire;
                    end
                end
            end
            ModeRestart: begin
                has_res      = 1'b1;
                kcmd.restart = fire;
            end
            ModeClear: begin
                has_res    = 1'b1;
                acmd.clear = fire;
                kcmd.clear = fire;
            end
            default: begin
                has_res = 1'b0;
            end
        endcase
    end

    kvc_alpha u_alpha (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (acmd),
        .i_c_letter (q_letter),
        .i_k_letter (kstat.letter),
        .i_decrypt  (decrypt),
        .o_stat     (astat)
    );

    kvc_keyword u_keyword (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (kcmd),
        .o_stat  (kstat)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= has_res;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_res) begin
            r_out_char   <= res_char;
            r_out_status <= st;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.out_char = r_out_char;
    assign o_rsp.status   = r_out_status;
endmodule
